// ----- sv/dtr_pkg.sv -----
package dtr_pkg;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Register selects
    localparam logic [1:0] REG_DIVIDER = 2'd0;
    localparam logic [1:0] REG_COUNTER = 2'd1;
    localparam logic [1:0] REG_RELOAD  = 2'd2;
    localparam logic [1:0] REG_CONTROL = 2'd3;

    // Control register: upper bits always read as one, bit 2 runs the timer
    localparam logic [7:0] CONTROL_FORCED = 8'hF8;
    localparam int         CONTROL_RUN    = 2;

    localparam logic [7:0] COUNTER_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] reg_sel;
        logic [7:0] write_data;
    } req_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
    } rsp_item_t;

endpackage

// ----- sv/dtr_core.sv -----
module dtr_core #(
    parameter int DIV_SHIFT        = 8,
    parameter int TIMER_SHIFT_BASE = 4,
    parameter int CPU_TICK_CYCLES  = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  dtr_pkg::req_item_t item,
    output dtr_pkg::rsp_item_t result
);
    import dtr_pkg::*;

    localparam logic [2:0] TICK_FULL = 3'(CPU_TICK_CYCLES);
    localparam logic [2:0] TICK_LAST = 3'(CPU_TICK_CYCLES - 1);

    logic [15:0] div_reg,     div_next;
    logic [9:0]  phase_reg,   phase_next;
    logic [7:0]  cnt_reg,     cnt_next;
    logic [7:0]  reload_reg,  reload_next;
    logic [7:0]  ctrl_reg,    ctrl_next;
    logic [2:0]  rcd_reg,     rcd_next;
    logic [2:0]  icd_reg,     icd_next;

    logic [3:0]  shift_amt;
    logic [10:0] period;
    logic [9:0]  mask;
    logic [9:0]  half;
    logic [9:0]  phase_inc;
    logic [9:0]  phase_off;
    logic        running;
    logic        tick_edge;
    logic        dist_ge_half;
    logic        jump_ticks;
    logic [7:0]  jump_base;
    logic [7:0]  jump_cnt;
    logic        jump_irq;
    logic [7:0]  tick_cnt;

    // Period select: codes 0..3 map to shifts base+6, base, base+2, base+4
    always_comb
    begin
        unique case (ctrl_reg[1:0])
            2'd0:    shift_amt = 4'(TIMER_SHIFT_BASE + 6);
            2'd1:    shift_amt = 4'(TIMER_SHIFT_BASE);
            2'd2:    shift_amt = 4'(TIMER_SHIFT_BASE + 2);
            default: shift_amt = 4'(TIMER_SHIFT_BASE + 4);
        endcase
    end

    assign period       = 11'd1 << shift_amt;
    assign mask         = 10'(period - 11'd1);
    assign half         = 10'(period >> 1);
    assign running      = ctrl_reg[CONTROL_RUN];
    assign phase_inc    = phase_reg + 10'd1;
    assign tick_edge    = (phase_inc & mask) == 10'd0;
    assign phase_off    = phase_reg & mask;
    assign dist_ge_half = phase_off >= half;

    // Running control write: counter steps if offset + half + tick - 1 >= period
    assign jump_ticks = ({1'b0, phase_off} + {1'b0, half} + 11'(CPU_TICK_CYCLES - 1)) >= period;
    assign jump_base  = (icd_reg != 3'd0 || rcd_reg != 3'd0) ? reload_reg : cnt_reg;
    assign jump_irq   = (icd_reg != 3'd0) || (cnt_reg == COUNTER_MAX && dist_ge_half);

    always_comb
    begin
        jump_cnt = jump_base;
        if (jump_ticks)
        begin
            if (jump_base == COUNTER_MAX)
                jump_cnt = dist_ge_half ? reload_reg : 8'd0;
            else
                jump_cnt = jump_base + 8'd1;
        end
    end

    always_comb
    begin
        div_next         = div_reg;
        phase_next       = phase_reg;
        cnt_next         = cnt_reg;
        reload_next      = reload_reg;
        ctrl_next        = ctrl_reg;
        rcd_next         = rcd_reg;
        icd_next         = icd_reg;
        tick_cnt         = cnt_reg;
        result.read_data = 8'd0;
        result.timer_irq = 1'b0;
        unique case (item.cmd)
            CMD_TICK:
            begin
                div_next   = div_reg + 16'd1;
                phase_next = phase_inc;
                if (rcd_reg != 3'd0)
                    rcd_next = rcd_reg - 3'd1;
                if (icd_reg != 3'd0)
                begin
                    icd_next = icd_reg - 3'd1;
                    if (icd_reg == 3'd1)
                    begin
                        tick_cnt         = reload_reg;
                        rcd_next         = TICK_FULL;
                        result.timer_irq = 1'b1;
                    end
                end
                if (running && tick_edge)
                begin
                    if (tick_cnt == COUNTER_MAX)
                    begin
                        tick_cnt = 8'd0;
                        icd_next = TICK_LAST;
                    end
                    else
                    begin
                        tick_cnt = tick_cnt + 8'd1;
                    end
                end
                cnt_next = tick_cnt;
            end
            CMD_READ:
            begin
                unique case (item.reg_sel)
                    REG_DIVIDER: result.read_data = div_reg[DIV_SHIFT +: 8];
                    REG_COUNTER: result.read_data = cnt_reg;
                    REG_RELOAD:  result.read_data = reload_reg;
                    default:     result.read_data = ctrl_reg;
                endcase
            end
            CMD_WRITE:
            begin
                unique case (item.reg_sel)
                    REG_DIVIDER:
                    begin
                        div_next = 16'd0;
                    end
                    REG_COUNTER:
                    begin
                        // drop the write while the copy countdown stands at TICK_LAST
                        if (rcd_reg != TICK_LAST)
                        begin
                            icd_next = 3'd0;
                            rcd_next = 3'd0;
                            cnt_next = item.write_data;
                        end
                    end
                    REG_RELOAD:
                    begin
                        reload_next = item.write_data;
                        if (rcd_reg != 3'd0)
                            cnt_next = item.write_data;
                    end
                    default:
                    begin
                        if (running)
                        begin
                            cnt_next         = jump_cnt;
                            result.timer_irq = jump_irq;
                            icd_next         = 3'd0;
                            rcd_next         = 3'd0;
                        end
                        ctrl_next = item.write_data | CONTROL_FORCED;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg    <= 16'd0;
            phase_reg  <= 10'd0;
            cnt_reg    <= 8'd0;
            reload_reg <= 8'd0;
            ctrl_reg   <= CONTROL_FORCED;
            rcd_reg    <= 3'd0;
            icd_reg    <= 3'd0;
        end
        else if (advance)
        begin
            div_reg    <= div_next;
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            reload_reg <= reload_next;
            ctrl_reg   <= ctrl_next;
            rcd_reg    <= rcd_next;
            icd_reg    <= icd_next;
        end
    end

    a_ctrl_forced: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg & CONTROL_FORCED) == CONTROL_FORCED)
        else $error("control register lost its forced upper bits");

    a_icd_range: assert property (@(posedge clk) disable iff (!rst_n)
        icd_reg <= TICK_LAST && rcd_reg <= TICK_FULL)
        else $error("countdown out of range");

    a_copy_opens_window: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.cmd == CMD_TICK && icd_reg == 3'd1 |=> rcd_reg == TICK_FULL)
        else $error("reload copy did not open the write window");

    a_irq_source: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.timer_irq |-> item.cmd == CMD_TICK || item.cmd == CMD_WRITE)
        else $error("interrupt raised by a read");

endmodule

// ----- sv/divider_timer_with_reload_top.sv -----
// Channel  Direction  Payload      Handshake
// req      in         req_item_t   req_valid / req_stall   (cmd, reg_sel, write_data)
// rsp      out        rsp_item_t   rsp_valid / rsp_stall   (read_data, timer_irq)
//
// One item per clock sustained while rsp is not stalled; an accepted item sits in the
// input register, and when it advances its result is loaded into the result register
// through the timer update and then offered on rsp. The timer state advances when an
// item leaves the input register.
// Reset (rst_n low, asynchronous) clears divider, phase, counter and reload to zero,
// control to 0xF8 (stopped), and empties both registers.
// A stall on rsp holds the result register; the input register keeps taking items as
// long as the result register is free or being drained in the same cycle.
module divider_timer_with_reload_top #(
    parameter int DIV_SHIFT        = 8,
    parameter int TIMER_SHIFT_BASE = 4,
    parameter int CPU_TICK_CYCLES  = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  dtr_pkg::req_item_t req_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output dtr_pkg::rsp_item_t rsp_item
);
    import dtr_pkg::*;

    logic      s1_valid_reg;
    req_item_t s1_item_reg;
    logic      rsp_valid_reg;
    rsp_item_t rsp_item_reg;
    logic      advance;
    rsp_item_t core_result;

    // Move the held item on whenever the result register is empty or being taken
    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!req_stall)
            s1_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            s1_item_reg <= req_item;
    end

    // Timer registers and per-item update
    dtr_core #(
        .DIV_SHIFT        (DIV_SHIFT),
        .TIMER_SHIFT_BASE (TIMER_SHIFT_BASE),
        .CPU_TICK_CYCLES  (CPU_TICK_CYCLES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .result  (core_result)
    );

    // Result register: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_item_reg <= core_result;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    a_free_result_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid_reg |-> !req_stall)
        else $error("input stalled while the result register was free");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg)
        else $error("advanced item produced no result");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
        else $error("stalled result changed or vanished");

endmodule
